// ----- rtl/core/tetc_pkg.sv -----
// ----------------------------------------------------------------------------
// Element type cast package
// Type codes, format constants and result struct shared by the cast blocks.
// ----------------------------------------------------------------------------
package tetc_pkg;

    localparam logic [2:0] TY_F16  = 3'd0;
    localparam logic [2:0] TY_F32  = 3'd1;
    localparam logic [2:0] TY_F64  = 3'd2;
    localparam logic [2:0] TY_I64  = 3'd3;
    localparam logic [2:0] TY_BOOL = 3'd4;

    // Configuration register indexes.
    localparam logic [0:0] CFG_SOURCE_TYPE = 1'b0;
    localparam logic [0:0] CFG_DEST_TYPE   = 1'b1;

    localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] QNAN64  = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] QNAN32  = 64'h0000_0000_7FC0_0000;

    // One converted element with its status flag.
    typedef struct packed {
        logic [63:0] bits;
        logic        unsupported;
    } cast_result_t;

endpackage

// ----- rtl/core/tetc_float_to_int.sv -----
// ----------------------------------------------------------------------------
// Float to int64
// Truncating, saturating conversion of fp16 or fp32 to int64.
// ----------------------------------------------------------------------------
module tetc_float_to_int
(
    input  logic [31:0] word,
    input  logic        is_f32,
    output logic [63:0] result
);

    logic        sign;
    logic [7:0]  expo;
    logic [22:0] frac;
    logic        all_ones;
    logic [7:0]  bias;
    logic [7:0]  unb;
    logic [63:0] mant;
    logic [63:0] mag;

    // Unpack into a common layout with the fraction left aligned on bit 22.
    always_comb
    begin
        if (is_f32)
        begin
            sign     = word[31];
            expo     = word[30:23];
            frac     = word[22:0];
            all_ones = (word[30:23] == 8'hFF);
            bias     = 8'd127;
        end
        else
        begin
            sign     = word[15];
            expo     = {3'd0, word[14:10]};
            frac     = {word[9:0], 13'd0};
            all_ones = (word[14:10] == 5'h1F);
            bias     = 8'd15;
        end
    end

    // Value is 1.frac * 2^(expo-bias); below one truncates to zero.
    always_comb
    begin
        unb  = expo - bias;
        mant = {40'd0, 1'b1, frac};
        mag  = '0;
        if (all_ones)
            result = (frac != '0) ? tetc_pkg::I64_MAX
                                  : (sign ? tetc_pkg::I64_MIN : tetc_pkg::I64_MAX);
        else if (expo < bias)
            result = '0;
        else if (unb >= 8'd63)
            result = sign ? tetc_pkg::I64_MIN : tetc_pkg::I64_MAX;
        else
        begin
            if (unb >= 8'd23)
                mag = mant << (unb - 8'd23);
            else
                mag = mant >> (8'd23 - unb);
            result = sign ? (64'd0 - mag) : mag;
        end
    end

endmodule

// ----- rtl/core/tetc_pack_float.sv -----
// ----------------------------------------------------------------------------
// Float packer
// Rounds a normalised 64-bit magnitude to fp16, fp32 or fp64, nearest even.
// ----------------------------------------------------------------------------
module tetc_pack_float
(
    input  logic              sign,
    input  logic [63:0]       norm,     // leading one on bit 63
    input  logic signed [12:0] uexp,    // unbiased exponent of bit 63
    input  logic [2:0]        dest,
    output logic [63:0]       result
);

    logic [5:0]         fbits;
    logic signed [12:0] bias;
    logic [11:0]        maxexp;
    logic signed [12:0] biased;
    logic [6:0]         sh;
    logic [127:0]       wide;
    logic [127:0]       shifted;
    logic [63:0]        q;
    logic               rbit;
    logic               sticky;
    logic [64:0]        qr;
    logic [63:0]        mfield;
    logic [12:0]        efield;

    // Format constants by destination.
    always_comb
    begin
        case (dest)
            tetc_pkg::TY_F16:
            begin
                fbits = 6'd10; bias = 13'sd15; maxexp = 12'd31;
            end
            tetc_pkg::TY_F32:
            begin
                fbits = 6'd23; bias = 13'sd127; maxexp = 12'd255;
            end
            default:
            begin
                fbits = 6'd52; bias = 13'sd1023; maxexp = 12'd2047;
            end
        endcase
    end

    // Shift so that the kept bits sit at the bottom; subnormals shift further.
    always_comb
    begin
        biased = uexp + bias;
        if (biased < 13'sd1)
        begin
            if ((13'sd1 - biased) > 13'sd64)
                sh = 7'd127;
            else
                sh = 7'(13'sd63 - 13'(fbits) + 13'sd1 - biased);
        end
        else
            sh = 7'(7'd63 - 7'(fbits));
        wide    = {norm, 64'd0};
        shifted = (sh == 7'd127) ? 128'd0 : (wide >> sh);
        q       = shifted[127:64];
        rbit    = shifted[63];
        sticky  = (shifted[62:0] != '0) || ((sh == 7'd127) && (norm != '0));
        qr      = {1'b0, q} + 65'(rbit && (sticky || q[0]));
    end

    // Carry of the mantissa into the exponent is absorbed by the field add.
    always_comb
    begin
        if (biased < 13'sd1)
            efield = '0;
        else
            efield = 13'(biased - 13'sd1);
        mfield = qr[63:0];
        // Exponent plus mantissa (with hidden bit) add as one field.
        result = (64'(efield) << fbits) + mfield;
        if ((result >> fbits) >= 64'(maxexp))
            result = 64'(maxexp) << fbits;
        result = result | (64'(sign) << (fbits + ((dest == tetc_pkg::TY_F16) ? 6'd5 :
                 (dest == tetc_pkg::TY_F32) ? 6'd8 : 6'd11)));
    end

endmodule

// ----- rtl/core/tetc_convert.sv -----
// ----------------------------------------------------------------------------
// Conversion datapath
// Combinational cast of one element for the configured type pair.
// ----------------------------------------------------------------------------
module tetc_convert
(
    input  logic [63:0]            x,
    input  logic [2:0]             src,
    input  logic [2:0]             dest,
    output tetc_pkg::cast_result_t res
);

    logic [63:0]        f2i;
    logic               pk_sign;
    logic [63:0]        mag;
    logic [63:0]        norm;
    logic [5:0]         lz;
    logic signed [12:0] src_exp;
    logic signed [12:0] uexp;
    logic [63:0]        packed_bits;
    logic               is_int;
    logic               f_nan;
    logic               f_inf;
    logic               f_zero;

    tetc_float_to_int u_f2i
    (
        .word   (x[31:0]),
        .is_f32 (src == tetc_pkg::TY_F32),
        .result (f2i)
    );

    // Source magnitude and exponent of its leading bit.
    always_comb
    begin
        is_int  = (src == tetc_pkg::TY_I64) || (src == tetc_pkg::TY_BOOL);
        pk_sign = 1'b0;
        mag     = '0;
        src_exp = '0;
        f_nan   = 1'b0;
        f_inf   = 1'b0;
        f_zero  = 1'b0;
        case (src)
            tetc_pkg::TY_I64:
            begin
                pk_sign = x[63];
                mag     = x[63] ? (64'd0 - x) : x;
            end
            tetc_pkg::TY_BOOL:
                mag = {56'd0, x[7:0]};
            tetc_pkg::TY_F32:
            begin
                pk_sign = x[31];
                f_nan   = (x[30:23] == 8'hFF) && (x[22:0] != '0);
                f_inf   = (x[30:23] == 8'hFF) && (x[22:0] == '0);
                f_zero  = (x[30:0] == '0);
                mag     = {x[30:23] != '0, x[22:0], 40'd0};
                src_exp = (x[30:23] == '0) ? -13'sd126 : 13'(x[30:23]) - 13'sd127;
            end
            default:
            begin
                pk_sign = x[63];
                f_nan   = (x[62:52] == 11'h7FF) && (x[51:0] != '0);
                f_inf   = (x[62:52] == 11'h7FF) && (x[51:0] == '0);
                f_zero  = (x[62:0] == '0);
                mag     = {x[62:52] != '0, x[51:0], 11'd0};
                src_exp = (x[62:52] == '0) ? -13'sd1022 : 13'(x[62:52]) - 13'sd1023;
            end
        endcase
    end

    // Normalise with a leading-zero count.
    always_comb
    begin
        lz = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (mag[i])
                lz = 6'(63 - i);
        end
        norm = mag << lz;
        if (is_int)
            uexp = 13'sd63 - 13'(lz);
        else
            uexp = src_exp - 13'(lz);
    end

    tetc_pack_float u_pack
    (
        .sign   (pk_sign),
        .norm   (norm),
        .uexp   (uexp),
        .dest   (dest),
        .result (packed_bits)
    );

    // Pair selection.
    always_comb
    begin
        res.bits        = '0;
        res.unsupported = 1'b0;
        if (src <= tetc_pkg::TY_BOOL && src == dest)
        begin
            case (src)
                tetc_pkg::TY_F16:  res.bits = {48'd0, x[15:0]};
                tetc_pkg::TY_F32:  res.bits = {32'd0, x[31:0]};
                tetc_pkg::TY_BOOL: res.bits = {56'd0, x[7:0]};
                default:           res.bits = x;
            endcase
        end
        else if ((src == tetc_pkg::TY_F16 || src == tetc_pkg::TY_F32) &&
                 dest == tetc_pkg::TY_I64)
            res.bits = f2i;
        else if (src == tetc_pkg::TY_F16 && dest == tetc_pkg::TY_BOOL)
            res.bits = 64'(x[14:0] != '0);
        else if (src == tetc_pkg::TY_F32 && dest == tetc_pkg::TY_BOOL)
            res.bits = 64'(x[30:0] != '0);
        else if (src == tetc_pkg::TY_I64 && dest == tetc_pkg::TY_BOOL)
            res.bits = 64'(x != '0);
        else if (src == tetc_pkg::TY_BOOL && dest == tetc_pkg::TY_I64)
            res.bits = {56'd0, x[7:0]};
        else if ((src == tetc_pkg::TY_F32 && dest == tetc_pkg::TY_F64) ||
                 (src == tetc_pkg::TY_F64 && dest == tetc_pkg::TY_F32))
        begin
            if (f_nan)
                res.bits = (dest == tetc_pkg::TY_F64) ? tetc_pkg::QNAN64
                                                      : tetc_pkg::QNAN32;
            else if (f_inf)
                res.bits = (dest == tetc_pkg::TY_F64) ? {pk_sign, 11'h7FF, 52'd0}
                                                      : {32'd0, pk_sign, 8'hFF, 23'd0};
            else if (f_zero)
                res.bits = (dest == tetc_pkg::TY_F64) ? {pk_sign, 63'd0}
                                                      : {32'd0, pk_sign, 31'd0};
            else
                res.bits = packed_bits;
        end
        else if (is_int && (dest == tetc_pkg::TY_F16 || dest == tetc_pkg::TY_F32))
            res.bits = (mag == '0) ? 64'd0 : packed_bits;
        else
            res.unsupported = 1'b1;
    end

endmodule

// ----- rtl/core/tensor_element_type_cast.sv -----
// ----------------------------------------------------------------------------
// Tensor element type cast
// Streams elements through a combinational cast between configured types.
// ----------------------------------------------------------------------------
// Stages: from input accept into the input register, then into the result register.
// Throughput: one item per cycle unless stalled, set by the single registered conversion pass.
// The output register takes a new item whenever it is empty or being drained.
// Reset: both types return to fp32 and both stages are emptied.
module tensor_element_type_cast
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [63:0] source_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [63:0] result_bits
    output logic        m_tuser      // [0] status
);

    logic [2:0]             src_reg;
    logic [2:0]             dest_reg;
    logic                   in_valid_reg;
    logic [63:0]            in_data_reg;
    logic                   out_valid_reg;
    tetc_pkg::cast_result_t out_reg;
    tetc_pkg::cast_result_t conv;
    logic                   out_free;
    logic                   in_free;

    assign out_free = !out_valid_reg || m_tready;
    assign in_free  = !in_valid_reg || out_free;
    assign s_tready = in_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg  <= tetc_pkg::TY_F32;
            dest_reg <= tetc_pkg::TY_F32;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tetc_pkg::CFG_SOURCE_TYPE)
                src_reg <= cfg_data;
            else
                dest_reg <= cfg_data;
        end
    end

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_free)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_free && s_tvalid)
            in_data_reg <= s_tdata;
    end

    tetc_convert u_convert
    (
        .x    (in_data_reg),
        .src  (src_reg),
        .dest (dest_reg),
        .res  (conv)
    );

    // Result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && in_valid_reg)
            out_reg <= conv;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.bits;
    assign m_tuser  = out_reg.unsupported;

`ifndef SYNTH
    // An unsupported pair always carries a zero result.
    a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("unsupported result not zero");

    // A stalled result is held.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");

    // Input stage moves on when the result stage is free.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_free |=> out_valid_reg)
        else $error("item lost between stages");
`endif

endmodule
